/* src/bst_pkg.sv */
// bst_pkg: shared types, codes and sizes for the bounded set table.
// No dependencies; used by every module of the block and by the checker.
package bst_pkg;

  // Table sizing
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;

  // Value returned on a read past the count (the pattern of -1.0)
  localparam logic [KEY_W-1:0] NEG_ONE_BITS = 64'hBFF0_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_BADIDX  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SWAP,
    S_READ
  } state_t;

  // Operands for the shared key compare unit
  typedef struct packed {
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
  } cmp_req_t;

  // Finished item from the sequencer
  typedef struct packed {
    logic             valid;
    status_t          status;
    logic             found;
    logic [KEY_W-1:0] value;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

/* src/bounded_set_table_core.sv */
// bounded_set_table_core: top level of the bounded set table.
// Depends on bst_pkg, bst_seq and bst_keycmp.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | in_opcode, in_key, in_index             | start high while busy low
//  result  | out_status, out_found, out_value,       | out_strobe, one cycle,
//          | out_count                               | no back-pressure
//
// One item at a time. Insert, remove and lookup walk the stored entries one
// per cycle through the single key comparator, stopping early on a hit; a
// remove that hits then moves the last entry into the freed slot. A read
// fetches its entry without a scan. The strobe cycle has busy low, so a new
// item can start then. Reset clears the count; entries hold no reset value.
module bounded_set_table_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_opcode,
  input  logic [bst_pkg::KEY_W-1:0] in_key,
  input  logic [bst_pkg::IDX_W-1:0] in_index,
  output logic                      out_strobe,
  output logic [2:0]                out_status,
  output logic                      out_found,
  output logic [bst_pkg::KEY_W-1:0] out_value,
  output logic [bst_pkg::CNT_W-1:0] out_count
);

  bst_pkg::cmp_req_t cmp_req;
  logic              cmp_match;
  bst_pkg::res_t     res;

  logic                      strobe_r;
  logic [2:0]                status_r;
  logic                      found_r;
  logic [bst_pkg::KEY_W-1:0] value_r;
  logic [bst_pkg::CNT_W-1:0] count_r;

  bst_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .in_key    (in_key),
    .in_index  (in_index),
    .busy      (busy),
    .cmp_req   (cmp_req),
    .cmp_match (cmp_match),
    .res       (res)
  );

  bst_keycmp u_keycmp (
    .req   (cmp_req),
    .match (cmp_match)
  );

  // Result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status_r <= res.status;
      found_r  <= res.found;
      value_r  <= res.value;
      count_r  <= res.count;
    end
  end

  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign out_found  = found_r;
  assign out_value  = value_r;
  assign out_count  = count_r;

endmodule

/* src/bst_keycmp.sv */
// bst_keycmp: IEEE-style equality of two double bit patterns.
// Depends on bst_pkg for the request struct.
module bst_keycmp (
  input  bst_pkg::cmp_req_t req,
  output logic              match
);

  logic a_nan;
  logic b_nan;
  logic both_zero;

  // NaN: exponent all ones, fraction nonzero
  assign a_nan = (&req.a[62:52]) && (|req.a[51:0]);
  assign b_nan = (&req.b[62:52]) && (|req.b[51:0]);

  // +0 and -0 compare equal
  assign both_zero = (req.a[62:0] == 63'd0) && (req.b[62:0] == 63'd0);

  assign match = !a_nan && !b_nan && (both_zero || (req.a == req.b));

endmodule

/* src/bst_seq.sv */
// bst_seq: sequencer and entry memory for the bounded set table.
// Depends on bst_pkg; the key compare result comes from bst_keycmp.
module bst_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [1:0]                 in_opcode,
  input  logic [bst_pkg::KEY_W-1:0]  in_key,
  input  logic [bst_pkg::IDX_W-1:0]  in_index,
  output logic                       busy,
  output bst_pkg::cmp_req_t          cmp_req,
  input  logic                       cmp_match,
  output bst_pkg::res_t              res
);

  localparam int IW = bst_pkg::IDX_W;
  localparam int CW = bst_pkg::CNT_W;
  localparam int KW = bst_pkg::KEY_W;

  bst_pkg::state_t state_r, state_nxt;
  bst_pkg::op_t    op_r, op_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [KW-1:0]   val_r, val_nxt;

  // Entry memory: one write port, one registered read port
  logic [KW-1:0]   mem [bst_pkg::CAPACITY];
  logic [KW-1:0]   rdata_r;
  logic [IW-1:0]   raddr;
  logic            we;
  logic [IW-1:0]   waddr;
  logic [KW-1:0]   wdata;

  logic            hit;
  logic            more;
  logic [CW-1:0]   last_w;

  assign hit    = chk_vld_r && cmp_match;
  assign more   = (ptr_r < cnt_r);
  assign last_w = cnt_r - 1'b1;

  assign cmp_req.a = rdata_r;
  assign cmp_req.b = key_r;
  assign busy      = (state_r != bst_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bst_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (bst_pkg::op_t'(in_opcode) == bst_pkg::OP_READ) ?
                      bst_pkg::S_READ : bst_pkg::S_SCAN;
        end
      end
      bst_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt = (op_r == bst_pkg::OP_REMOVE) ? bst_pkg::S_SWAP : bst_pkg::S_IDLE;
        end else if (!more) begin
          state_nxt = bst_pkg::S_IDLE;
        end
      end
      bst_pkg::S_SWAP: state_nxt = bst_pkg::S_IDLE;
      bst_pkg::S_READ: state_nxt = bst_pkg::S_IDLE;
      default:         state_nxt = bst_pkg::S_IDLE;
    endcase
  end

  // Datapath control and results
  always_comb begin
    op_nxt      = op_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    ptr_nxt     = ptr_r;
    chk_vld_nxt = 1'b0;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    val_nxt     = val_r;
    raddr       = ptr_r[IW-1:0];
    we          = 1'b0;
    waddr       = pos_r;
    wdata       = rdata_r;
    res         = '0;
    unique case (state_r)
      bst_pkg::S_IDLE: begin
        // Latch the item; a read fetches its entry right away
        if (start) begin
          op_nxt  = bst_pkg::op_t'(in_opcode);
          key_nxt = in_key;
          idx_nxt = in_index;
          ptr_nxt = '0;
          raddr   = in_index;
        end
      end
      bst_pkg::S_SCAN: begin
        if (hit) begin
          res.found = 1'b1;
          case (op_r)
            bst_pkg::OP_INSERT: begin
              res.valid  = 1'b1;
              res.status = bst_pkg::ST_DUP;
            end
            bst_pkg::OP_REMOVE: begin
              // keep removed key, fetch the last entry for the swap
              val_nxt = rdata_r;
              raddr   = last_w[IW-1:0];
            end
            default: begin
              res.valid  = 1'b1;
              res.status = bst_pkg::ST_OK;
            end
          endcase
          res.count = cnt_r;
        end else if (more) begin
          // issue the next entry; its compare happens next cycle
          raddr       = ptr_r[IW-1:0];
          ptr_nxt     = ptr_r + 1'b1;
          chk_vld_nxt = 1'b1;
          pos_nxt     = ptr_r[IW-1:0];
        end else begin
          // scan exhausted: key absent
          res.valid = 1'b1;
          case (op_r)
            bst_pkg::OP_INSERT: begin
              if (cnt_r == CW'(bst_pkg::CAPACITY)) begin
                res.status = bst_pkg::ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = cnt_r[IW-1:0];
                wdata      = key_r;
                cnt_nxt    = cnt_r + 1'b1;
                res.status = bst_pkg::ST_OK;
              end
            end
            bst_pkg::OP_REMOVE: res.status = bst_pkg::ST_MISSING;
            default:            res.status = bst_pkg::ST_OK;
          endcase
          res.count = cnt_nxt;
        end
      end
      bst_pkg::S_SWAP: begin
        // move the last entry into the freed slot
        we         = 1'b1;
        waddr      = pos_r;
        wdata      = rdata_r;
        cnt_nxt    = last_w;
        res.valid  = 1'b1;
        res.status = bst_pkg::ST_OK;
        res.found  = 1'b1;
        res.value  = val_r;
        res.count  = last_w;
      end
      bst_pkg::S_READ: begin
        res.valid = 1'b1;
        res.count = cnt_r;
        if (CW'(idx_r) < cnt_r) begin
          res.status = bst_pkg::ST_OK;
          res.value  = rdata_r;
        end else begin
          res.status = bst_pkg::ST_BADIDX;
          res.value  = bst_pkg::NEG_ONE_BITS;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bst_pkg::S_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      ptr_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
      ptr_r     <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    key_r <= key_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
  end

endmodule

/* src/bst_checker.sv */
// bst_checker: port-level assertions for bounded_set_table_core, plus bind.
// Depends on bst_pkg for codes and sizes.
module bst_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_strobe,
  input logic [2:0]                out_status,
  input logic                      out_found,
  input logic [bst_pkg::KEY_W-1:0] out_value,
  input logic [bst_pkg::CNT_W-1:0] out_count
);

  // An accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Every finished item gives exactly one strobe
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("item finished without a result");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe lasted more than one cycle");

  // Count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_count <= bst_pkg::CNT_W'(bst_pkg::CAPACITY)))
    else $error("count beyond capacity");

  // Bad index returns -1.0 and no hit
  a_badidx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == bst_pkg::ST_BADIDX)) |->
      ((out_value == bst_pkg::NEG_ONE_BITS) && !out_found))
    else $error("bad index result malformed");

endmodule

bind bounded_set_table_core bst_checker u_bst_checker (.*);

/* tb/bst_result_check.sv */
`timescale 1ns / 100ps
// bst_result_check: watches both channels of the bounded set table, keeps its
// own copy of the stored keys and compares every result with the predicted one.
// Depends on bst_pkg for sizes and codes.
module bst_result_check (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                in_opcode,
  input  logic [bst_pkg::KEY_W-1:0] in_key,
  input  logic [bst_pkg::IDX_W-1:0] in_index,
  input  logic                      out_strobe,
  input  logic [2:0]                out_status,
  input  logic                      out_found,
  input  logic [bst_pkg::KEY_W-1:0] out_value,
  input  logic [bst_pkg::CNT_W-1:0] out_count,
  output int                        mismatches,
  output int                        pending
);
  import bst_pkg::*;

  typedef struct {
    status_t          status;
    logic             found;
    logic [KEY_W-1:0] value;
    logic [CNT_W-1:0] count;
  } outcome_t;

  // Mirror of the table contents
  logic [KEY_W-1:0] stored_keys [CAPACITY];
  int               stored_cnt;
  outcome_t         awaited_results [$];
  int               errs;

  initial begin
    mismatches = 0;
    pending    = 0;
    errs       = 0;
    stored_cnt = 0;
  end

  function automatic bit is_nan(input logic [KEY_W-1:0] k);
    return (k[62:52] == 11'h7FF) && (k[51:0] != '0);
  endfunction

  // IEEE equality: NaN matches nothing, +0 and -0 match each other
  function automatic bit keys_equal(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[62:0] == '0 && b[62:0] == '0) return 1'b1;
    return a == b;
  endfunction

  // First matching slot, -1 when absent
  function automatic int find_slot(input logic [KEY_W-1:0] k);
    for (int i = 0; i < stored_cnt; i++)
      if (keys_equal(stored_keys[i], k)) return i;
    return -1;
  endfunction

  // Applies one item to the mirror and returns the result it must produce
  function automatic outcome_t table_outcome(input op_t op, input logic [KEY_W-1:0] key,
                                             input logic [IDX_W-1:0] idx);
    outcome_t o;
    int       slot;
    o.status = ST_OK;
    o.found  = 1'b0;
    o.value  = '0;
    case (op)
      OP_INSERT: begin
        slot = find_slot(key);
        if (slot >= 0) begin
          o.status = ST_DUP;
          o.found  = 1'b1;
        end else if (stored_cnt >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          stored_keys[stored_cnt] = key;
          stored_cnt++;
        end
      end
      OP_REMOVE: begin
        slot = find_slot(key);
        if (slot >= 0) begin
          o.found = 1'b1;
          o.value = stored_keys[slot];
          // last entry moves into the hole
          stored_keys[slot] = stored_keys[stored_cnt-1];
          stored_cnt--;
        end else begin
          o.status = ST_MISSING;
        end
      end
      OP_LOOKUP: o.found = (find_slot(key) >= 0);
      default: begin
        if (int'(idx) < stored_cnt) begin
          o.value = stored_keys[idx];
        end else begin
          o.status = ST_BADIDX;
          o.value  = NEG_ONE_BITS;
        end
      end
    endcase
    o.count = stored_cnt[CNT_W-1:0];
    return o;
  endfunction

  task automatic note_failure(input string msg);
    errs++;
    if (errs <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Results are checked before a new item is taken at the same edge
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst_n) begin
      stored_cnt = 0;
      awaited_results.delete();
    end else begin
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d found %0d value %h count %0d",
                                 out_status, out_found, out_value, out_count));
        end else begin
          exp_o = awaited_results.pop_front();
          if (out_status !== exp_o.status || out_found !== exp_o.found ||
              out_value !== exp_o.value || out_count !== exp_o.count)
            note_failure($sformatf({"result mismatch: expected status %0d found %0d ",
                                    "value %h count %0d, got status %0d found %0d ",
                                    "value %h count %0d"},
                                   exp_o.status, exp_o.found, exp_o.value, exp_o.count,
                                   out_status, out_found, out_value, out_count));
        end
      end
      if (start && !busy)
        awaited_results.push_back(table_outcome(op_t'(in_opcode), in_key, in_index));
    end
    pending    <= awaited_results.size();
    mismatches <= errs;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench: drives directed and random items into bounded_set_table_core and
// gives the verdict. Depends on bst_pkg, the block and bst_result_check.
module testbench;
  import bst_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_opcode;
  logic [KEY_W-1:0] in_key;
  logic [IDX_W-1:0] in_index;
  logic             out_strobe;
  logic [2:0]       out_status;
  logic             out_found;
  logic [KEY_W-1:0] out_value;
  logic [CNT_W-1:0] out_count;
  int               mismatches;
  int               pending;

  logic [KEY_W-1:0] key_pool [24];
  int               insert_pct;
  bit               no_gaps;

  always #5 clk = ~clk;

  bounded_set_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_opcode (in_opcode),
    .in_key    (in_key),
    .in_index  (in_index),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_found (out_found),
    .out_value (out_value),
    .out_count (out_count)
  );

  bst_result_check result_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_opcode (in_opcode),
    .in_key    (in_key),
    .in_index  (in_index),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_found (out_found),
    .out_value (out_value),
    .out_count (out_count),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Pool keys make hits and duplicates common; specials hit the IEEE corners
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return key_pool[$urandom_range(0, 23)];
    if (r < 78) begin
      case ($urandom_range(0, 6))
        0:       return 64'h0000_0000_0000_0000;
        1:       return 64'h8000_0000_0000_0000;
        2:       return 64'h7FF0_0000_0000_0000;
        3:       return 64'hFFF0_0000_0000_0000;
        4:       return 64'h7FF8_0000_0000_0000;
        5:       return 64'h7FF0_0000_0000_0001;
        default: return 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  // Hold the item until the block takes it, then maybe drop start for a while
  task automatic apply_item(input op_t op, input logic [KEY_W-1:0] key,
                            input logic [IDX_W-1:0] idx);
    int gap;
    in_opcode <= op;
    in_key    <= key;
    in_index  <= idx;
    start     <= 1'b1;
    do @(posedge clk); while (!(start && !busy));
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Watchdog
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int  r;
    op_t op;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_opcode <= OP_INSERT;
    in_key    <= '0;
    in_index  <= '0;
    insert_pct = 50;
    no_gaps    = 1'b0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, signed zeros, NaN and infinity handling
    apply_item(OP_READ,   '0, 4'd0);
    apply_item(OP_LOOKUP, '0, 4'd0);
    apply_item(OP_REMOVE, '0, 4'd0);
    apply_item(OP_INSERT, 64'h0000_0000_0000_0000, 4'd0);
    apply_item(OP_INSERT, 64'h8000_0000_0000_0000, 4'd0);
    apply_item(OP_LOOKUP, 64'h8000_0000_0000_0000, 4'd0);
    apply_item(OP_INSERT, 64'h7FF8_0000_0000_0000, 4'd0);
    apply_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    apply_item(OP_LOOKUP, 64'h7FF8_0000_0000_0000, 4'd0);
    apply_item(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    apply_item(OP_INSERT, 64'h7FF0_0000_0000_0000, 4'd0);
    apply_item(OP_INSERT, 64'h7FF0_0000_0000_0000, 4'd0);
    apply_item(OP_READ,   '0, 4'd15);
    // Fill to capacity, then overflow, duplicate when full and read the top slot
    for (int i = 0; i < 12; i++) apply_item(OP_INSERT, key_pool[i], 4'd0);
    apply_item(OP_INSERT, key_pool[12], 4'd0);
    apply_item(OP_INSERT, key_pool[3], 4'd0);
    apply_item(OP_READ,   '0, 4'd15);
    // Remove a signed zero by its twin (swap from the end), then the last entry
    apply_item(OP_REMOVE, 64'h8000_0000_0000_0000, 4'd0);
    apply_item(OP_REMOVE, key_pool[10], 4'd0);

    // Random: each phase picks a new insert share, so the table fills or drains
    for (int n = 0; n < 1900; n++) begin
      if (n % 60 == 0) begin
        insert_pct = $urandom_range(10, 70);
        no_gaps    = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < insert_pct) op = OP_INSERT;
      else if (r < 80)    op = OP_REMOVE;
      else if (r < 90)    op = OP_LOOKUP;
      else                op = OP_READ;
      apply_item(op, pick_key(), IDX_W'($urandom_range(0, 15)));
    end
    start <= 1'b0;

    // Drain, then allow for the longest item latency
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
